>>> rtl/core/itp_pkg.sv
// Shared types, character constants and operator helpers for the infix to postfix converter.
`default_nettype none

package itp_pkg;

    localparam int STACK_DEPTH = 32;
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_CARET  = 8'h5E;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_NUL    = 8'h00;

    typedef enum logic [2:0] {
        OP_LPAREN = 3'd0,
        OP_PLUS   = 3'd1,
        OP_MINUS  = 3'd2,
        OP_MUL    = 3'd3,
        OP_DIV    = 3'd4,
        OP_POW    = 3'd5
    } op_code_t;

    typedef enum logic [2:0] {
        CL_END,
        CL_DIGIT,
        CL_OP,
        CL_LPAREN,
        CL_RPAREN,
        CL_OTHER
    } sym_class_t;

    typedef struct packed {
        logic     push;
        logic     pop;
        op_code_t code;
    } stack_ctl_t;

    function automatic sym_class_t classify(input logic kind, input logic [7:0] s);
        sym_class_t cl;
        cl = CL_OTHER;
        if (kind)
        begin
            cl = CL_END;
        end
        else
        begin
            case (s) inside
                [CH_ZERO:CH_NINE]:                           cl = CL_DIGIT;
                CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH, CH_CARET: cl = CL_OP;
                CH_LPAREN:                                   cl = CL_LPAREN;
                CH_RPAREN:                                   cl = CL_RPAREN;
                default:                                     cl = CL_OTHER;
            endcase
        end
        return cl;
    endfunction

    function automatic op_code_t char_to_op(input logic [7:0] s);
        op_code_t op;
        case (s)
            CH_PLUS:  op = OP_PLUS;
            CH_MINUS: op = OP_MINUS;
            CH_STAR:  op = OP_MUL;
            CH_SLASH: op = OP_DIV;
            CH_CARET: op = OP_POW;
            default:  op = OP_LPAREN;
        endcase
        return op;
    endfunction

    function automatic logic [7:0] op_to_char(input op_code_t op);
        logic [7:0] c;
        case (op)
            OP_LPAREN: c = CH_LPAREN;
            OP_PLUS:   c = CH_PLUS;
            OP_MINUS:  c = CH_MINUS;
            OP_MUL:    c = CH_STAR;
            OP_DIV:    c = CH_SLASH;
            OP_POW:    c = CH_CARET;
            default:   c = CH_NUL;
        endcase
        return c;
    endfunction

    function automatic logic [1:0] op_prec(input op_code_t op);
        logic [1:0] p;
        case (op)
            OP_PLUS, OP_MINUS: p = 2'd1;
            OP_MUL, OP_DIV:    p = 2'd2;
            OP_POW:            p = 2'd3;
            default:           p = 2'd0;
        endcase
        return p;
    endfunction

    // True when a stacked operator must be popped before the incoming one is pushed.
    function automatic logic must_pop(input op_code_t stacked, input op_code_t incoming);
        logic r;
        if (stacked == OP_LPAREN)
        begin
            r = 1'b0;
        end
        else if (incoming == OP_POW)
        begin
            r = op_prec(stacked) > op_prec(incoming);
        end
        else
        begin
            r = op_prec(stacked) >= op_prec(incoming);
        end
        return r;
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/itp_cell.sv
// One stack cell: holds a single operator code and shifts with its neighbors.
`default_nettype none

module itp_cell (
    input  wire                  clk,
    input  itp_pkg::stack_ctl_t  ctl,
    input  itp_pkg::op_code_t    from_above,
    input  itp_pkg::op_code_t    from_below,
    output itp_pkg::op_code_t    code
);

    itp_pkg::op_code_t code_reg;
    itp_pkg::op_code_t code_next;

    always_comb
    begin
        code_next = code_reg;
        if (ctl.push)
        begin
            code_next = from_above;
        end
        else if (ctl.pop)
        begin
            code_next = from_below;
        end
    end

    always_ff @(posedge clk)
    begin
        code_reg <= code_next;
    end

    assign code = code_reg;

endmodule

`default_nettype wire

>>> rtl/core/itp_stack.sv
// Operator stack built as a row of shifting cells; cell 0 is the top of the stack.
`default_nettype none

module itp_stack (
    input  wire                  clk,
    input  itp_pkg::stack_ctl_t  ctl,
    output itp_pkg::op_code_t    top_code,
    output itp_pkg::op_code_t    second_code
);

    itp_pkg::op_code_t codes [itp_pkg::STACK_DEPTH];

    genvar i;
    generate
        for (i = 0; i < itp_pkg::STACK_DEPTH; i++)
        begin : g_cell
            itp_pkg::op_code_t above;
            itp_pkg::op_code_t below;

            if (i == 0)
            begin : g_first
                assign above = ctl.code;
            end
            else
            begin : g_mid_above
                assign above = codes[i - 1];
            end

            if (i == itp_pkg::STACK_DEPTH - 1)
            begin : g_last
                assign below = codes[i];
            end
            else
            begin : g_mid_below
                assign below = codes[i + 1];
            end

            itp_cell u_cell (
                .clk        (clk),
                .ctl        (ctl),
                .from_above (above),
                .from_below (below),
                .code       (codes[i])
            );
        end
    endgenerate

    assign top_code    = codes[0];
    assign second_code = codes[1];

endmodule

`default_nettype wire

>>> rtl/core/infix_to_postfix_converter.sv
// Top level of the infix to postfix converter: item control, counters and output register.
// Characters enter one beat at a time and leave in postfix order, one result beat per cycle
// while the output register is not held. An item is first accepted and then pops stack
// entries one at a time (emitted or discarded), plus a closing step to push an operator or
// '(', to emit a digit or the done marker, to finish a ')' that finds no '(' or to drop an
// ignored character; a ')' that meets its '(' needs no closing step. A new item is taken
// only once the last one is through. Steps that emit a result wait while the output
// register is held. The operator stack is a row of cells that shifts by one entry per
// cycle. The sticky error flag is cleared only by reset.
`default_nettype none

module infix_to_postfix_converter (
    input  wire        clk,
    input  wire        rst_n,
    input  wire        in_valid,
    output logic       in_stall,
    input  wire        kind,
    input  wire  [7:0] symbol,
    output logic       out_valid,
    input  wire        out_stall,
    output logic [7:0] out_symbol,
    output logic       has_symbol,
    output logic       last_of_run,
    output logic       expression_done,
    output logic       error_flag
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_WORK = 2'b10
    } state_t;

    localparam logic [itp_pkg::CNT_W-1:0] FULL  = itp_pkg::CNT_W'(itp_pkg::STACK_DEPTH);
    localparam logic [itp_pkg::CNT_W-1:0] ONE   = itp_pkg::CNT_W'(1);
    localparam logic [itp_pkg::CNT_W-1:0] EMPTY = '0;

    state_t                      state_reg, state_next;
    logic [itp_pkg::CNT_W-1:0]   count_reg, count_next;
    logic [itp_pkg::CNT_W-1:0]   paren_reg, paren_next;
    logic                        err_reg, err_next;
    itp_pkg::sym_class_t         class_reg, class_next;
    itp_pkg::op_code_t           op_reg, op_next;
    logic [7:0]                  sym_reg, sym_next;

    logic                        out_valid_reg, out_valid_next;
    logic [7:0]                  out_symbol_reg, out_symbol_next;
    logic                        has_symbol_reg, has_symbol_next;
    logic                        last_reg, last_next;
    logic                        done_reg, done_next;
    logic                        err_out_reg, err_out_next;

    itp_pkg::stack_ctl_t         ctl;
    itp_pkg::op_code_t           top_code;
    itp_pkg::op_code_t           second_code;

    logic                        accept;
    logic                        slot_free;
    itp_pkg::sym_class_t         in_class;
    logic                        emit;
    logic [7:0]                  e_sym;
    logic                        e_has;
    logic                        e_last;
    logic                        e_done;

    itp_stack u_stack (
        .clk         (clk),
        .ctl         (ctl),
        .top_code    (top_code),
        .second_code (second_code)
    );

    assign in_stall  = (state_reg != ST_IDLE);
    assign accept    = in_valid && !in_stall;
    assign slot_free = !out_valid_reg || !out_stall;
    assign in_class  = itp_pkg::classify(kind, symbol);

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        paren_next = paren_reg;
        err_next   = err_reg;
        class_next = class_reg;
        op_next    = op_reg;
        sym_next   = sym_reg;
        ctl.push   = 1'b0;
        ctl.pop    = 1'b0;
        ctl.code   = op_reg;
        emit       = 1'b0;
        e_sym      = itp_pkg::op_to_char(top_code);
        e_has      = 1'b1;
        e_last     = 1'b0;
        e_done     = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    class_next = in_class;
                    sym_next   = symbol;
                    op_next    = itp_pkg::char_to_op(symbol);
                    state_next = ST_WORK;
                    // Parenthesis mismatches are known from the open count up front, so the
                    // flag is already right on every result this item gives.
                    if ((in_class == itp_pkg::CL_END && paren_reg != EMPTY) ||
                        (in_class == itp_pkg::CL_RPAREN && paren_reg == EMPTY))
                    begin
                        err_next = 1'b1;
                    end
                end
            end

            ST_WORK:
            begin
                case (class_reg)
                    itp_pkg::CL_END:
                    begin
                        if (slot_free)
                        begin
                            if (count_reg != EMPTY)
                            begin
                                ctl.pop = 1'b1;
                                emit    = (top_code != itp_pkg::OP_LPAREN);
                            end
                            else
                            begin
                                emit       = 1'b1;
                                e_sym      = itp_pkg::CH_NUL;
                                e_has      = 1'b0;
                                e_last     = 1'b1;
                                e_done     = 1'b1;
                                state_next = ST_IDLE;
                            end
                        end
                    end

                    itp_pkg::CL_DIGIT:
                    begin
                        if (slot_free)
                        begin
                            emit       = 1'b1;
                            e_sym      = sym_reg;
                            e_last     = 1'b1;
                            state_next = ST_IDLE;
                        end
                    end

                    itp_pkg::CL_OP:
                    begin
                        if (count_reg != EMPTY && itp_pkg::must_pop(top_code, op_reg))
                        begin
                            if (slot_free)
                            begin
                                ctl.pop = 1'b1;
                                emit    = 1'b1;
                                e_last  = !((count_reg > ONE) &&
                                            itp_pkg::must_pop(second_code, op_reg));
                            end
                        end
                        else
                        begin
                            if (count_reg == FULL)
                            begin
                                err_next = 1'b1;
                            end
                            else
                            begin
                                ctl.push = 1'b1;
                            end
                            state_next = ST_IDLE;
                        end
                    end

                    itp_pkg::CL_LPAREN:
                    begin
                        ctl.code = itp_pkg::OP_LPAREN;
                        if (count_reg == FULL)
                        begin
                            err_next = 1'b1;
                        end
                        else
                        begin
                            ctl.push = 1'b1;
                        end
                        state_next = ST_IDLE;
                    end

                    itp_pkg::CL_RPAREN:
                    begin
                        if (count_reg == EMPTY)
                        begin
                            state_next = ST_IDLE;
                        end
                        else if (top_code == itp_pkg::OP_LPAREN)
                        begin
                            ctl.pop    = 1'b1;
                            state_next = ST_IDLE;
                        end
                        else if (slot_free)
                        begin
                            ctl.pop = 1'b1;
                            emit    = 1'b1;
                            e_last  = (count_reg == ONE) ||
                                      (second_code == itp_pkg::OP_LPAREN);
                        end
                    end

                    default:
                    begin
                        state_next = ST_IDLE;
                    end
                endcase
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (ctl.pop)
        begin
            count_next = count_reg - ONE;
            if (top_code == itp_pkg::OP_LPAREN)
            begin
                paren_next = paren_reg - ONE;
            end
        end
        else if (ctl.push)
        begin
            count_next = count_reg + ONE;
            if (ctl.code == itp_pkg::OP_LPAREN)
            begin
                paren_next = paren_reg + ONE;
            end
        end
    end

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_symbol_next = out_symbol_reg;
        has_symbol_next = has_symbol_reg;
        last_next       = last_reg;
        done_next       = done_reg;
        err_out_next    = err_out_reg;
        if (emit)
        begin
            out_valid_next  = 1'b1;
            out_symbol_next = e_sym;
            has_symbol_next = e_has;
            last_next       = e_last;
            done_next       = e_done;
            err_out_next    = err_reg;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= EMPTY;
            paren_reg     <= EMPTY;
            err_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            paren_reg     <= paren_next;
            err_reg       <= err_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        class_reg      <= class_next;
        op_reg         <= op_next;
        sym_reg        <= sym_next;
        out_symbol_reg <= out_symbol_next;
        has_symbol_reg <= has_symbol_next;
        last_reg       <= last_next;
        done_reg       <= done_next;
        err_out_reg    <= err_out_next;
    end

    assign out_valid       = out_valid_reg;
    assign out_symbol      = out_symbol_reg;
    assign has_symbol      = has_symbol_reg;
    assign last_of_run     = last_reg;
    assign expression_done = done_reg;
    assign error_flag      = err_out_reg;

endmodule

`default_nettype wire
